/* rtl/core/pan_tilt_servo_slew_positioner_defines.svh */
// assertion macros for the pan/tilt positioner
`ifndef PAN_TILT_SERVO_SLEW_POSITIONER_DEFINES_SVH
`define PAN_TILT_SERVO_SLEW_POSITIONER_DEFINES_SVH

// condition holds at every edge outside reset
`define PTS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pts_pkg.sv */
package pts_pkg;

   typedef enum logic {
      REQ_SET  = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [7:0] rotate;
      logic [7:0] tilt;
   } goal_type;

   // angle + ANGLE_BIAS is never negative and keeps the value mod 360
   localparam logic signed [16:0] ANGLE_BIAS = 17'sd33120;
   // floor(u / 360) = (u * MOD_RECIP) >> MOD_SHIFT for u below 75239
   localparam logic [15:0] MOD_RECIP = 16'd46604;
   localparam int unsigned MOD_SHIFT = 24;
   localparam logic [16:0] MOD_BASE = 17'd360;

   localparam logic [8:0] DEG_HALF = 9'd180;
   localparam logic [8:0] DEG_FOLD = 9'd270;

   // floor(pos * 7.38) = (pos * CMP_SCALE) >> CMP_SHIFT for pos up to 180
   localparam logic [18:0] CMP_SCALE = 19'd483656;
   localparam int unsigned CMP_SHIFT = 16;
   localparam logic [11:0] CMP_OFFSET = 12'd820;

   function automatic logic [11:0] to_compare(input logic [7:0] pos);
      logic [26:0] prod;
      prod = 27'(pos) * 27'(CMP_SCALE);
      return 12'(prod >> CMP_SHIFT) + CMP_OFFSET;
   endfunction

   function automatic logic [7:0] mod_quotient(input logic [16:0] u);
      logic [32:0] prod;
      prod = 33'(u) * 33'(MOD_RECIP);
      return 8'(prod >> MOD_SHIFT);
   endfunction

endpackage

/* rtl/core/pan_tilt_servo_slew_positioner.sv */
// each accepted request beat becomes a response beat in order, stage by stage
// throughput: one beat per cycle while rsp_stall allows; an input register, a bias
// and quotient stage and a remainder and fold stage precede a slew and response stage
// reset: synchronous, active high; positions, goals and the step counter clear,
// step interval returns to 1, all pipeline stages empty
module pan_tilt_servo_slew_positioner
   import pts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [0:0]          req_type,
   input  logic signed [15:0]  req_rotate_angle,
   input  logic signed [15:0]  req_tilt_angle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [11:0]         rsp_rotate_compare,
   output logic [11:0]         rsp_tilt_compare,
   output logic [7:0]          rsp_rotate_position,
   output logic [7:0]          rsp_tilt_position,
   output logic                rsp_moving,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_step_interval
);

`include "pan_tilt_servo_slew_positioner_defines.svh"

   logic         s1_valid_ff;
   req_kind_type s1_kind_ff;
   logic signed [15:0] s1_rotate_ff;
   logic signed [15:0] s1_tilt_ff;

   logic         s2_valid_ff;
   req_kind_type s2_kind_ff;
   logic [16:0]  s2_rotate_biased_ff;
   logic [16:0]  s2_tilt_biased_ff;
   logic [7:0]   s2_rotate_quot_ff;
   logic [7:0]   s2_tilt_quot_ff;

   logic         s3_valid_ff;
   req_kind_type s3_kind_ff;
   goal_type     s3_goal_ff;

   logic         rsp_valid_ff;
   logic [11:0]  rsp_rotate_compare_ff;
   logic [11:0]  rsp_tilt_compare_ff;
   logic [7:0]   rsp_rotate_position_ff;
   logic [7:0]   rsp_tilt_position_ff;
   logic         rsp_moving_ff;

   logic [15:0]  step_interval_ff;
   logic [7:0]   rotate_pos_ff, rotate_pos_in;
   logic [7:0]   tilt_pos_ff, tilt_pos_in;
   logic [7:0]   rotate_goal_ff, rotate_goal_in;
   logic [7:0]   tilt_goal_ff, tilt_goal_in;
   logic [15:0]  interval_count_ff, interval_count_in;

   logic         out_free;
   logic         s3_free;
   logic         s2_free;
   logic         s1_free;
   logic         req_accept;
   logic         s3_fire;

   logic signed [16:0] rotate_ext;
   logic signed [16:0] tilt_ext;
   logic [16:0]  rotate_biased;
   logic [16:0]  tilt_biased;
   goal_type     fold_goal;

   logic         moving_now;
   logic         moving_after;
   logic [15:0]  step_limit;
   logic [15:0]  count_inc;

   // pipeline flow
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s3_free    = !s3_valid_ff || out_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && s1_free;
   assign s3_fire    = s3_valid_ff && out_free;
   assign csr_ready  = 1'b1;

   // stage 1 to 2: bias and quotient
   assign rotate_ext    = {s1_rotate_ff[15], s1_rotate_ff};
   assign tilt_ext      = {s1_tilt_ff[15], s1_tilt_ff};
   assign rotate_biased = 17'(rotate_ext + ANGLE_BIAS);
   assign tilt_biased   = 17'(tilt_ext + ANGLE_BIAS);

   // stage 2 to 3: remainder and fold
   pts_angle_fold u_fold (
      .rotate_biased (s2_rotate_biased_ff),
      .rotate_quot   (s2_rotate_quot_ff),
      .tilt_biased   (s2_tilt_biased_ff),
      .tilt_quot     (s2_tilt_quot_ff),
      .goal          (fold_goal)
   );

   // stage 3: slew state
   assign moving_now = (rotate_pos_ff != rotate_goal_ff) || (tilt_pos_ff != tilt_goal_ff);
   assign step_limit = (step_interval_ff == '0) ? 16'd1 : step_interval_ff;
   assign count_inc  = interval_count_ff + 16'd1;
   assign moving_after = (rotate_pos_in != rotate_goal_in) || (tilt_pos_in != tilt_goal_in);

   always_comb begin
      rotate_pos_in     = rotate_pos_ff;
      tilt_pos_in       = tilt_pos_ff;
      rotate_goal_in    = rotate_goal_ff;
      tilt_goal_in      = tilt_goal_ff;
      interval_count_in = interval_count_ff;
      if (s3_fire) begin
         unique case (s3_kind_ff)
            REQ_SET: begin
               rotate_goal_in    = s3_goal_ff.rotate;
               tilt_goal_in      = s3_goal_ff.tilt;
               interval_count_in = '0;
            end
            REQ_TICK: begin
               if (moving_now) begin
                  if (count_inc >= step_limit) begin
                     interval_count_in = '0;
                     if (rotate_pos_ff != rotate_goal_ff) begin
                        if (rotate_pos_ff < rotate_goal_ff) begin
                           rotate_pos_in = rotate_pos_ff + 8'd1;
                        end else begin
                           rotate_pos_in = rotate_pos_ff - 8'd1;
                        end
                     end else if (tilt_pos_ff < tilt_goal_ff) begin
                        tilt_pos_in = tilt_pos_ff + 8'd1;
                     end else begin
                        tilt_pos_in = tilt_pos_ff - 8'd1;
                     end
                  end else begin
                     interval_count_in = count_inc;
                  end
               end else begin
                  interval_count_in = '0;
               end
            end
            default: begin
               interval_count_in = interval_count_ff;
            end
         endcase
         if (!moving_after) begin
            interval_count_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         step_interval_ff  <= 16'd1;
         rotate_pos_ff     <= '0;
         tilt_pos_ff       <= '0;
         rotate_goal_ff    <= '0;
         tilt_goal_ff      <= '0;
         interval_count_ff <= '0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         if (csr_valid) begin
            step_interval_ff <= csr_step_interval;
         end
         rotate_pos_ff     <= rotate_pos_in;
         tilt_pos_ff       <= tilt_pos_in;
         rotate_goal_ff    <= rotate_goal_in;
         tilt_goal_ff      <= tilt_goal_in;
         interval_count_ff <= interval_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= req_kind_type'(req_type);
         s1_rotate_ff <= req_rotate_angle;
         s1_tilt_ff   <= req_tilt_angle;
      end
      if (s1_valid_ff && s2_free) begin
         s2_kind_ff          <= s1_kind_ff;
         s2_rotate_biased_ff <= rotate_biased;
         s2_tilt_biased_ff   <= tilt_biased;
         s2_rotate_quot_ff   <= mod_quotient(rotate_biased);
         s2_tilt_quot_ff     <= mod_quotient(tilt_biased);
      end
      if (s2_valid_ff && s3_free) begin
         s3_kind_ff <= s2_kind_ff;
         s3_goal_ff <= fold_goal;
      end
      if (s3_fire) begin
         rsp_rotate_compare_ff  <= to_compare(rotate_pos_in);
         rsp_tilt_compare_ff    <= to_compare(tilt_pos_in);
         rsp_rotate_position_ff <= rotate_pos_in;
         rsp_tilt_position_ff   <= tilt_pos_in;
         rsp_moving_ff          <= moving_after;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rotate_compare  = rsp_rotate_compare_ff;
   assign rsp_tilt_compare    = rsp_tilt_compare_ff;
   assign rsp_rotate_position = rsp_rotate_position_ff;
   assign rsp_tilt_position   = rsp_tilt_position_ff;
   assign rsp_moving          = rsp_moving_ff;

   // checks
   `PTS_ASSERT_ALWAYS(a_count_idle, moving_now || (interval_count_ff == '0),
      "count not clear while idle")
   `PTS_ASSERT_NEXT(a_one_axis, 1'b1, $stable(rotate_pos_ff) || $stable(tilt_pos_ff),
      "both axes moved in one beat")
   `PTS_ASSERT_NEXT(a_rotate_step, 1'b1,
      (rotate_pos_ff == $past(rotate_pos_ff)) ||
      (rotate_pos_ff == 8'($past(rotate_pos_ff) + 8'd1)) ||
      (rotate_pos_ff == 8'($past(rotate_pos_ff) - 8'd1)),
      "rotate jumped more than one degree")
   `PTS_ASSERT_NEXT(a_state_hold, !s3_fire,
      $stable(rotate_pos_ff) && $stable(tilt_pos_ff) &&
      $stable(rotate_goal_ff) && $stable(tilt_goal_ff),
      "state changed without a beat")

endmodule

/* rtl/core/pts_angle_fold.sv */
module pts_angle_fold
   import pts_pkg::*;
(
   input  logic [16:0] rotate_biased,
   input  logic [7:0]  rotate_quot,
   input  logic [16:0] tilt_biased,
   input  logic [7:0]  tilt_quot,
   output goal_type    goal
);

   logic [16:0] rotate_rem;
   logic [16:0] tilt_rem;
   logic [8:0]  rotate_deg;
   logic [8:0]  tilt_deg;
   logic [8:0]  tilt_clip;
   logic [8:0]  rotate_half;
   logic [8:0]  tilt_final;

   assign rotate_rem = rotate_biased - 17'(rotate_quot) * MOD_BASE;
   assign tilt_rem   = tilt_biased - 17'(tilt_quot) * MOD_BASE;
   assign rotate_deg = rotate_rem[8:0];
   assign tilt_deg   = tilt_rem[8:0];

   always_comb begin
      priority if (tilt_deg >= DEG_FOLD) begin
         tilt_clip = '0;
      end else if (tilt_deg > DEG_HALF) begin
         tilt_clip = DEG_HALF;
      end else begin
         tilt_clip = tilt_deg;
      end
   end

   always_comb begin
      if (rotate_deg > DEG_HALF) begin
         rotate_half = rotate_deg - DEG_HALF;
         tilt_final  = DEG_HALF - tilt_clip;
      end else begin
         rotate_half = rotate_deg;
         tilt_final  = tilt_clip;
      end
   end

   assign goal.rotate = 8'(DEG_HALF - rotate_half);
   assign goal.tilt   = tilt_final[7:0];

endmodule
